// File: rtl/mofb_pkg.sv
// shared types and constants for the monochrome frame store with fill and scanout
// no dependencies
package mofb_pkg;

    localparam int DEF_SCREEN_WIDTH = 128;
    localparam int DEF_PAGE_COUNT   = 4;
    localparam int MAX_ROWS         = 64;
    localparam int COL_BITS         = 9;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0] CMD_SET_PAGE = 8'h22;
    localparam logic [7:0] CMD_COL_LOW  = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;

    typedef enum logic [1:0] {
        KIND_FILL  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_FILL,
        OP_CLEAR,
        OP_READ
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_FILL,
        BS_RDWAIT
    } t_bstate;

    // one queued job: fill span, clear, or one refresh byte
    typedef struct packed {
        t_op                   op;
        logic [COL_BITS-1:0]   x_lo;
        logic [COL_BITS-1:0]   x_hi;
        logic [MAX_ROWS-1:0]   mask;
        logic                  rd_cmd;
        logic [7:0]            rd_byte;
        logic [2:0]            rd_page;
        logic                  frame_end;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_qstat;

endpackage

// File: rtl/mono_oled_framebuffer_fill_scanout.sv
// monochrome page-organized frame store with rectangle fill, clear and refresh scanout
// path from accept to o_valid: a command byte passes the job queue and the output register,
// a data byte also passes the column read register on the way;
// a fill walks its clipped columns one at a time as a read-modify-write column walk
// reset: synchronous, clears the queue, refresh position and column valid bits,
// so the store reads as all zeros at once with no clearing pass
module mono_oled_framebuffer_fill_scanout #(
    parameter int SCREEN_WIDTH = mofb_pkg::DEF_SCREEN_WIDTH,
    parameter int PAGE_COUNT   = mofb_pkg::DEF_PAGE_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_start_x,
    input  logic [7:0] i_end_x,
    input  logic [7:0] i_start_y,
    input  logic [7:0] i_end_y,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_command,
    output logic       o_frame_end
);
    import mofb_pkg::*;

    logic   push, pop;
    t_cmd   push_cmd, head_cmd;
    t_qstat qstat;

    mofb_front #(
        .SCREEN_WIDTH(SCREEN_WIDTH),
        .PAGE_COUNT  (PAGE_COUNT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_kind   (i_kind),
        .i_start_x(i_start_x),
        .i_end_x  (i_end_x),
        .i_start_y(i_start_y),
        .i_end_y  (i_end_y),
        .i_qstat  (qstat),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    mofb_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_cmd  (head_cmd),
        .o_qstat(qstat)
    );

    mofb_back #(
        .SCREEN_WIDTH(SCREEN_WIDTH),
        .PAGE_COUNT  (PAGE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_is_command(o_is_command),
        .o_frame_end (o_frame_end)
    );

    // the last byte of a refresh is always a pixel data byte
    a_fend_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> !o_is_command)
        else $error("frame end flagged on a command byte");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> qstat.valid)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (qstat.full && !pop) |=> !(qstat.valid == 1'b0))
        else $error("queue lost entries while full");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

// File: rtl/mofb_front.sv
// front end: accepts items, tracks the refresh position, turns items into queue jobs
// except empty fills and unused kinds; depends on mofb_pkg
module mofb_front #(
    parameter int SCREEN_WIDTH = mofb_pkg::DEF_SCREEN_WIDTH,
    parameter int PAGE_COUNT   = mofb_pkg::DEF_PAGE_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_start_x,
    input  logic [7:0]        i_end_x,
    input  logic [7:0]        i_start_y,
    input  logic [7:0]        i_end_y,
    input  mofb_pkg::t_qstat  i_qstat,
    output logic              o_push,
    output mofb_pkg::t_cmd    o_cmd
);
    import mofb_pkg::*;

    localparam int ROWS  = PAGE_COUNT * 8;
    localparam int PG_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int OFF_W = $clog2(SCREEN_WIDTH + 4);

    logic [PG_W-1:0]     r_page, n_page;
    logic [OFF_W-1:0]    r_off, n_off;
    logic                accept;
    logic                page_last, off_last;
    logic [COL_BITS-1:0] x_hi;
    logic [ROWS-1:0]     mask;
    logic                fill_empty;

    assign o_ready   = !i_qstat.full;
    assign accept    = i_valid && o_ready;
    assign page_last = (r_page == PG_W'(PAGE_COUNT - 1));
    assign off_last  = (r_off == OFF_W'(SCREEN_WIDTH + 3));

    // clip the right edge to the screen
    assign x_hi = ({1'b0, i_end_x} > COL_BITS'(SCREEN_WIDTH)) ? COL_BITS'(SCREEN_WIDTH)
                                                               : {1'b0, i_end_x};

    always_comb begin
        for (int i = 0; i < ROWS; i++) begin
            mask[i] = (COL_BITS'(i) >= {1'b0, i_start_y}) && (COL_BITS'(i) < {1'b0, i_end_y});
        end
    end

    // covers inverted and fully clipped rectangles too
    assign fill_empty = (mask == '0) || ({1'b0, i_start_x} >= x_hi);

    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = OP_FILL;
        o_cmd.x_lo      = {1'b0, i_start_x};
        o_cmd.x_hi      = x_hi;
        o_cmd.mask      = MAX_ROWS'(mask);
        o_cmd.rd_page   = 3'(r_page);
        o_cmd.frame_end = page_last && off_last;
        o_push          = 1'b0;
        n_page          = r_page;
        n_off           = r_off;
        case (i_kind)
            KIND_FILL: begin
                o_push = accept && !fill_empty;
            end
            KIND_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                o_push   = accept;
            end
            KIND_READ: begin
                o_cmd.op = OP_READ;
                o_push   = accept;
                o_cmd.rd_cmd = (r_off < OFF_W'(4));
                case (r_off[1:0])
                    2'd0:    o_cmd.rd_byte = CMD_SET_PAGE;
                    2'd1:    o_cmd.rd_byte = 8'(r_page);
                    2'd2:    o_cmd.rd_byte = CMD_COL_LOW;
                    default: o_cmd.rd_byte = CMD_COL_HIGH;
                endcase
                o_cmd.x_lo = COL_BITS'(r_off) - COL_BITS'(4);
                if (accept) begin
                    if (off_last) begin
                        n_off  = '0;
                        n_page = page_last ? '0 : r_page + 1'b1;
                    end else begin
                        n_off = r_off + 1'b1;
                    end
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= '0;
            r_off  <= '0;
        end else begin
            r_page <= n_page;
            r_off  <= n_off;
        end
    end

endmodule

// File: rtl/mofb_queue.sv
// short job queue between front and back ends
// depends on mofb_pkg
module mofb_queue #(
    parameter int DEPTH = mofb_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mofb_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output mofb_pkg::t_cmd    o_cmd,
    output mofb_pkg::t_qstat  o_qstat
);
    import mofb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_entry [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_cmd         = r_entry[r_rp];
    assign o_qstat.valid = (r_cnt != '0);
    assign o_qstat.full  = (r_cnt == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

endmodule

// File: rtl/mofb_back.sv
// back end: column-organized frame memory, fill walker, clear and scanout byte read
// depends on mofb_pkg
module mofb_back #(
    parameter int SCREEN_WIDTH = mofb_pkg::DEF_SCREEN_WIDTH,
    parameter int PAGE_COUNT   = mofb_pkg::DEF_PAGE_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mofb_pkg::t_cmd    i_cmd,
    input  mofb_pkg::t_qstat  i_qstat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_is_command,
    output logic              o_frame_end
);
    import mofb_pkg::*;

    localparam int ROWS  = PAGE_COUNT * 8;
    localparam int PG_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int COL_W = $clog2(SCREEN_WIDTH);
    localparam int CNT_W = $clog2(SCREEN_WIDTH + 1);

    // one word per column, holding every page of that column
    logic [ROWS-1:0]         r_mem [SCREEN_WIDTH];
    logic [SCREEN_WIDTH-1:0] r_valid;

    t_bstate           r_state, n_state;
    logic [CNT_W-1:0]  r_x, r_xend;
    logic [ROWS-1:0]   r_mask;
    logic [PG_W-1:0]   r_page;
    logic              r_fend;
    logic              r_wr_pend;
    logic [COL_W-1:0]  r_wr_addr;
    logic [ROWS-1:0]   r_rd_data;
    logic              r_rd_vld;

    logic              r_out_valid, r_out_cmd, r_out_fend;
    logic [7:0]        r_out_byte;

    logic              out_free;
    logic              rd_en, clr, load_cmd, load_data;
    logic [COL_W-1:0]  rd_addr;
    logic [ROWS-1:0]   wr_data;
    logic [7:0]        data_byte;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_qstat.valid) begin
                    case (i_cmd.op)
                        OP_FILL: n_state = BS_FILL;
                        OP_READ: begin
                            if (out_free && !i_cmd.rd_cmd) begin
                                n_state = BS_RDWAIT;
                            end
                        end
                        default: n_state = BS_IDLE;
                    endcase
                end
            end
            BS_FILL: begin
                if (r_x == r_xend) begin
                    n_state = BS_IDLE;
                end
            end
            BS_RDWAIT: n_state = BS_IDLE;
            default:   n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_x[COL_W-1:0];
        clr       = 1'b0;
        load_cmd  = 1'b0;
        load_data = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (i_qstat.valid) begin
                    case (i_cmd.op)
                        OP_FILL: o_pop = 1'b1;
                        OP_CLEAR: begin
                            o_pop = 1'b1;
                            clr   = 1'b1;
                        end
                        OP_READ: begin
                            if (out_free) begin
                                o_pop    = 1'b1;
                                load_cmd = i_cmd.rd_cmd;
                                rd_en    = !i_cmd.rd_cmd;
                                rd_addr  = i_cmd.x_lo[COL_W-1:0];
                            end
                        end
                        default: o_pop = 1'b0;
                    endcase
                end
            end
            BS_FILL: begin
                rd_en = (r_x != r_xend);
            end
            BS_RDWAIT: begin
                load_data = 1'b1;
            end
            default: o_pop = 1'b0;
        endcase
    end

    assign wr_data   = (r_rd_vld ? r_rd_data : '0) | r_mask;
    assign data_byte = r_rd_vld ? r_rd_data[{r_page, 3'b000} +: 8] : 8'h00;

    // memory read and write-back of a filled column
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_valid[rd_addr];
        end
        if (r_wr_pend) begin
            r_mem[r_wr_addr] <= wr_data;
        end
        r_wr_addr <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && r_state == BS_IDLE) begin
            r_x    <= i_cmd.x_lo[CNT_W-1:0];
            r_xend <= i_cmd.x_hi[CNT_W-1:0];
            r_mask <= i_cmd.mask[ROWS-1:0];
            r_page <= i_cmd.rd_page[PG_W-1:0];
            r_fend <= i_cmd.frame_end;
        end else if (r_state == BS_FILL && rd_en) begin
            r_x <= r_x + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_wr_pend <= 1'b0;
            r_valid   <= '0;
        end else begin
            r_state   <= n_state;
            r_wr_pend <= rd_en && (r_state == BS_FILL);
            // clearing the column valid bits empties the whole store at once
            if (clr) begin
                r_valid <= '0;
            end else if (r_wr_pend) begin
                r_valid[r_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_cmd) begin
            r_out_valid <= 1'b1;
        end else if (load_data) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_cmd) begin
            r_out_byte <= i_cmd.rd_byte;
            r_out_cmd  <= 1'b1;
            r_out_fend <= i_cmd.frame_end;
        end else if (load_data) begin
            r_out_byte <= data_byte;
            r_out_cmd  <= 1'b0;
            r_out_fend <= r_fend;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_is_command = r_out_cmd;
    assign o_frame_end  = r_out_fend;

endmodule

// File: tb/mono_oled_framebuffer_fill_scanout_tb.sv
// testbench for the page-organized monochrome frame store with fill and refresh scanout
// holds its own frame model and refresh counter in a scoreboard class
// depends on rtl/mofb_pkg.sv and rtl/mono_oled_framebuffer_fill_scanout.sv
`timescale 1ns / 1ps

module mono_oled_framebuffer_fill_scanout_tb;
    import mofb_pkg::*;

    localparam int SCR_W       = DEF_SCREEN_WIDTH;
    localparam int SCR_PAGES   = DEF_PAGE_COUNT;
    localparam int SCR_H       = SCR_PAGES * 8;
    localparam int PAGE_BYTES  = 4 + SCR_W;
    localparam int FRAME_BYTES = SCR_PAGES * PAGE_BYTES;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEMS_PER_PHASE = 334;

    // the one kind code the block must ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [7:0] data;
        logic       cmd;
        logic       last;
    } t_refresh_byte;

    class t_frame_model;
        bit [7:0]      pixels [SCR_W*SCR_PAGES];
        int            scan_pos;
        t_refresh_byte pending_bytes [$];
        int            errors;
        int            n_fill, n_clear, n_read, n_ignored, n_checked, n_wraps;

        function new();
            foreach (pixels[i]) pixels[i] = 8'h00;
            scan_pos = 0;
            errors   = 0;
            n_fill = 0; n_clear = 0; n_read = 0; n_ignored = 0; n_checked = 0; n_wraps = 0;
        endfunction

        function void paint_rect(int x0, int x1, int y0, int y1);
            if (x1 < x0 || y1 < y0) return;
            if (x1 > SCR_W) x1 = SCR_W;
            if (y1 > SCR_H) y1 = SCR_H;
            for (int y = y0; y < y1; y++)
                for (int x = x0; x < x1; x++)
                    pixels[(y >> 3) * SCR_W + x] |= 8'(1 << (y & 7));
        endfunction

        function t_refresh_byte next_refresh_byte();
            t_refresh_byte rb;
            int page, off;
            page = scan_pos / PAGE_BYTES;
            off  = scan_pos % PAGE_BYTES;
            rb.cmd  = (off < 4);
            rb.last = (scan_pos == FRAME_BYTES - 1);
            case (off)
                0: rb.data = CMD_SET_PAGE;
                1: rb.data = 8'(page);
                2: rb.data = CMD_COL_LOW;
                3: rb.data = CMD_COL_HIGH;
                default: rb.data = pixels[page * SCR_W + off - 4];
            endcase
            scan_pos = (scan_pos + 1) % FRAME_BYTES;
            if (rb.last) n_wraps++;
            return rb;
        endfunction

        // called once per accepted input transaction
        function void note_item(logic [1:0] kind, logic [7:0] sx, logic [7:0] ex,
                                logic [7:0] sy, logic [7:0] ey);
            if (kind == KIND_FILL) begin
                paint_rect(sx, ex, sy, ey);
                n_fill++;
            end else if (kind == KIND_CLEAR) begin
                foreach (pixels[i]) pixels[i] = 8'h00;
                n_clear++;
            end else if (kind == KIND_READ) begin
                pending_bytes.push_back(next_refresh_byte());
                n_read++;
            end else begin
                n_ignored++;
            end
        endfunction

        function void check_byte(logic [7:0] data, logic cmd, logic last);
            t_refresh_byte exp_rb;
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected output byte %02h cmd %b end %b",
                         $time, data, cmd, last);
                errors++;
                return;
            end
            exp_rb = pending_bytes.pop_front();
            n_checked++;
            if (data !== exp_rb.data) begin
                $display("%0t: out_byte mismatch expected %02h actual %02h",
                         $time, exp_rb.data, data);
                errors++;
            end
            if (cmd !== exp_rb.cmd) begin
                $display("%0t: is_command mismatch expected %b actual %b",
                         $time, exp_rb.cmd, cmd);
                errors++;
            end
            if (last !== exp_rb.last) begin
                $display("%0t: frame_end mismatch expected %b actual %b",
                         $time, exp_rb.last, last);
                errors++;
            end
        endfunction

        function int pending_count();
            return pending_bytes.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_kind;
    logic [7:0] i_start_x;
    logic [7:0] i_end_x;
    logic [7:0] i_start_y;
    logic [7:0] i_end_y;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic       o_is_command;
    logic       o_frame_end;

    t_frame_model model;
    int send_idle;
    int recv_idle;
    int stall_cycles;

    mono_oled_framebuffer_fill_scanout DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_start_x    (i_start_x),
        .i_end_x      (i_end_x),
        .i_start_y    (i_start_y),
        .i_end_y      (i_end_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_is_command (o_is_command),
        .o_frame_end  (o_frame_end)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // output side: check each result transaction, randomize ready, track stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
            i_ready      <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                model.check_byte(o_out_byte, o_is_command, o_frame_end);
            if ((o_valid && i_ready) || (i_valid && o_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_item(logic [1:0] kind, logic [7:0] sx, logic [7:0] ex,
                             logic [7:0] sy, logic [7:0] ey);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_start_x <= sx;
        i_end_x   <= ex;
        i_start_y <= sy;
        i_end_y   <= ey;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        model.note_item(kind, sx, ex, sy, ey);
    endtask

    task automatic send_read();
        send_item(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // mostly small on-screen rectangles, some wild and some inverted ones
    task automatic send_random_fill();
        int sel, sx, sy;
        sel = $urandom_range(99);
        sx  = $urandom_range(SCR_W - 1);
        sy  = $urandom_range(SCR_H - 1);
        if (sel < 75)
            send_item(KIND_FILL, 8'(sx), 8'(sx + $urandom_range(24)),
                      8'(sy), 8'(sy + $urandom_range(10)));
        else if (sel < 88)
            send_item(KIND_FILL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else
            send_item(KIND_FILL, 8'(sx + 1 + $urandom_range(20)), 8'(sx),
                      8'(sy), 8'(sy + $urandom_range(10)));
    endtask

    task automatic run_random(int count);
        int done, sel, burst;
        done = 0;
        while (done < count) begin
            sel = $urandom_range(99);
            if (sel < 55) begin
                send_read();
                done++;
            end else if (sel < 62) begin
                // burst of reads to sweep the stream across page boundaries
                burst = $urandom_range(4, 40);
                repeat (burst) send_read();
                done += burst;
            end else if (sel < 93) begin
                send_random_fill();
                done++;
            end else if (sel < 95) begin
                send_item(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
                done++;
            end else begin
                send_item(KIND_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (model.pending_count() != 0) @(posedge i_clk);
    endtask

    initial begin
        model     = new();
        send_idle = 0;
        recv_idle = 0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_kind    <= KIND_FILL;
        i_start_x <= 8'h00;
        i_end_x   <= 8'h00;
        i_start_y <= 8'h00;
        i_end_y   <= 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: page 0 command bytes, clipping, empty and inverted fills
        send_read();
        send_read();
        send_read();
        send_read();
        send_read();
        send_item(KIND_FILL, 8'd0, 8'd255, 8'd0, 8'd255);
        send_read();
        send_item(KIND_CLEAR, 8'hff, 8'hff, 8'hff, 8'hff);
        send_item(KIND_FILL, 8'd10, 8'd5, 8'd0, 8'd32);
        send_item(KIND_FILL, 8'd0, 8'd128, 8'd20, 8'd19);
        send_item(KIND_FILL, 8'd5, 8'd5, 8'd0, 8'd8);
        send_item(KIND_FILL, 8'd200, 8'd255, 8'd40, 8'd255);
        send_item(KIND_FILL, 8'd0, 8'd1, 8'd0, 8'd1);
        send_item(KIND_FILL, 8'd2, 8'd4, 8'd7, 8'd9);
        send_item(KIND_FILL, 8'd127, 8'd128, 8'd31, 8'd32);
        send_item(KIND_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff);
        send_item(KIND_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00);
        send_read();
        send_read();
        send_read();
        send_read();
        send_read();
        send_read();

        send_idle = 13;
        recv_idle = 64;
        run_random(ITEMS_PER_PHASE);
        // hold the sender off until the output side has caught up
        wait_drained();

        send_idle = 64;
        recv_idle = 13;
        run_random(ITEMS_PER_PHASE);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        run_random(ITEMS_PER_PHASE);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d fills, %0d clears, %0d reads, %0d ignored items",
                 model.n_fill, model.n_clear, model.n_read, model.n_ignored);
        $display("checked %0d refresh bytes over %0d full frames, %0d errors",
                 model.n_checked, model.n_wraps, model.errors);
        if (model.errors == 0 && model.pending_count() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: mono_oled_framebuffer_fill_scanout.f
rtl/mofb_pkg.sv
rtl/mofb_front.sv
rtl/mofb_queue.sv
rtl/mofb_back.sv
rtl/mono_oled_framebuffer_fill_scanout.sv
tb/mono_oled_framebuffer_fill_scanout_tb.sv
